// ----- rtl/core/bpa_pkg.sv -----
// Shared types, constants and helpers of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int MAX_ORDER  = 10;
   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int ORD_W      = 4;
   localparam int SPAN_W     = ((PAGE_W > 16) ? PAGE_W : 16) + 1;
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int CIDX_W     = $clog2(MAX_ORDER);
   localparam int FIFO_DEPTH = 2;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_OOM         = 3'd1,
      ST_BAD_ORDER   = 3'd2,
      ST_DOUBLE_FREE = 3'd3,
      ST_RANGE       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      K_ALLOC,
      K_FREE,
      K_ERR
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [ORD_W-1:0]      order;
      logic [PAGE_W-1:0]     page;
      status_type            status;
   } cmd_type;

   typedef struct packed {
      logic [PAGE_W-1:0]     page;
      logic [ORD_W-1:0]      order;
      status_type            status;
   } result_type;

   typedef struct packed {
      logic                  free;
      logic [ORD_W-1:0]      order;
   } mem_word_type;

   typedef struct packed {
      logic                  full;
      logic                  empty;
   } fifo_status_type;

   typedef struct packed {
      logic                  init_done;
   } back_status_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_COV_RD,
      B_COV_CHK,
      B_ORD_RD,
      B_ORD_CHK,
      B_MRG_RD,
      B_MRG_CHK,
      B_FREE_WR,
      B_SCAN_RD,
      B_SCAN_CHK,
      B_SPLIT,
      B_ALLOC_WR,
      B_EMIT
   } back_state_type;

   function automatic logic [SPAN_W-1:0] pow2(input logic [ORD_W-1:0] o);
      return SPAN_W'(1) << o;
   endfunction
endpackage

// ----- rtl/core/bpa_if.sv -----
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
interface bpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [3:0]                  request_order;
   logic [bpa_pkg::PAGE_W-1:0]  target_page;
   modport source(output valid, command, request_order, target_page, input ready);
   modport sink(input valid, command, request_order, target_page, output ready);
endinterface

interface bpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bpa_pkg::PAGE_W-1:0]  block_page;
   logic [3:0]                  block_order;
   logic [2:0]                  status;
   modport source(output valid, block_page, block_order, status, input ready);
   modport sink(input valid, block_page, block_order, status, output ready);
endinterface

// ----- rtl/core/bpa_front.sv -----
// Front end: accepts request words and classifies them into queue commands.
`timescale 1ns / 1ps
module bpa_front (
   bpa_req_if.sink                   req_ch,
   input  bpa_pkg::fifo_status_type  fifo_status,
   input  bpa_pkg::back_status_type  back_status,
   output logic                      push,
   output bpa_pkg::cmd_type          entry
);
   import bpa_pkg::*;

   assign req_ch.ready = !fifo_status.full && back_status.init_done;
   assign push = req_ch.valid && req_ch.ready;

   always_comb begin
      entry.order  = req_ch.request_order;
      entry.page   = req_ch.target_page;
      entry.status = ST_OK;
      entry.kind   = K_ALLOC;
      if (req_ch.command == CMD_ALLOC) begin
         if (int'(req_ch.request_order) >= MAX_ORDER) begin
            entry.kind   = K_ERR;
            entry.status = ST_BAD_ORDER;
         end
      end else begin
         entry.kind = K_FREE;
         if (int'(req_ch.target_page) >= NUM_PAGES) begin
            entry.kind   = K_ERR;
            entry.status = ST_RANGE;
         end
      end
   end
endmodule

// ----- rtl/core/bpa_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module bpa_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bpa_pkg::cmd_type          push_data,
   input  logic                      pop,
   output bpa_pkg::cmd_type          pop_data,
   output bpa_pkg::fifo_status_type  fifo_status
);
   import bpa_pkg::*;

   cmd_type             slot_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data          = slot_ff[rd_ptr_ff];
   assign fifo_status.full  = (int'(cnt_ff) == FIFO_DEPTH);
   assign fifo_status.empty = (cnt_ff == '0);
endmodule

// ----- rtl/core/bpa_back.sv -----
// Back end: page state memory, per-order counts and the allocate/free sequencer.
`timescale 1ns / 1ps
module bpa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bpa_pkg::fifo_status_type  fifo_status,
   input  bpa_pkg::cmd_type          cmd,
   output logic                      pop,
   output bpa_pkg::back_status_type  back_status,
   bpa_rsp_if.source                 rsp_ch
);
   import bpa_pkg::*;

   mem_word_type        mem [NUM_PAGES];
   mem_word_type        rd_ff;
   logic                mem_we, mem_re;
   logic [PAGE_W-1:0]   mem_wa, mem_ra;
   mem_word_type        mem_wd;

   back_state_type      st_ff, st_in;
   logic [PAGE_W-1:0]   clr_ff, clr_in;
   logic [PAGE_W-1:0]   idx_ff, idx_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [ORD_W-1:0]    req_ord_ff, req_ord_in;
   logic [SPAN_W-1:0]   p_ff, p_in;
   logic [CNT_W-1:0]    cnt_ff [MAX_ORDER];
   logic [CNT_W-1:0]    cnt_in [MAX_ORDER];
   result_type          res_ff, res_in;
   result_type          out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                cnt_we, cnt_up;
   logic [CIDX_W-1:0]   cnt_idx;
   logic                fit_found;
   logic [ORD_W-1:0]    fit_ord;
   logic [SPAN_W-1:0]   bud;
   logic [SPAN_W-1:0]   half;
   logic [ORD_W-1:0]    ord_dn;

   // Smallest order at or above the request that still holds a free block.
   always_comb begin
      fit_found = 1'b0;
      fit_ord   = '0;
      for (int o = MAX_ORDER - 1; o >= 0; o--) begin
         if (ORD_W'(o) >= cmd.order && cnt_ff[o] != '0) begin
            fit_found = 1'b1;
            fit_ord   = ORD_W'(o);
         end
      end
   end

   always_comb begin
      for (int o = 0; o < MAX_ORDER; o++) begin
         cnt_in[o] = cnt_ff[o];
      end
      if (cnt_we) begin
         cnt_in[cnt_idx] = cnt_up ? cnt_ff[cnt_idx] + 1'b1 : cnt_ff[cnt_idx] - 1'b1;
      end
   end

   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      ord_in       = ord_ff;
      req_ord_in   = req_ord_ff;
      p_in         = p_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = '0;
      cnt_we       = 1'b0;
      cnt_up       = 1'b0;
      cnt_idx      = ord_ff[CIDX_W-1:0];
      bud          = p_ff ^ pow2(ord_ff);
      ord_dn       = ord_ff - 1'b1;
      half         = p_ff + pow2(ord_dn);
      unique case (st_ff)
         B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PAGE_W'(NUM_PAGES - 1)) begin
               st_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!fifo_status.empty) begin
               pop    = 1'b1;
               res_in = '{page: '0, order: '0, status: cmd.status};
               unique case (cmd.kind)
                  K_ERR: begin
                     st_in = B_EMIT;
                  end
                  K_ALLOC: begin
                     req_ord_in = cmd.order;
                     if (fit_found) begin
                        ord_in = fit_ord;
                        p_in   = '0;
                        st_in  = B_SCAN_RD;
                     end else begin
                        res_in.status = ST_OOM;
                        st_in         = B_EMIT;
                     end
                  end
                  default: begin
                     idx_in = cmd.page;
                     ord_in = '0;
                     st_in  = B_COV_RD;
                  end
               endcase
            end
         end
         B_COV_RD: begin
            mem_re = 1'b1;
            mem_ra = PAGE_W'(SPAN_W'(idx_ff) & ~(pow2(ord_ff) - 1'b1));
            st_in  = B_COV_CHK;
         end
         B_COV_CHK: begin
            if (rd_ff.free && rd_ff.order == ord_ff) begin
               res_in.status = ST_DOUBLE_FREE;
               st_in         = B_EMIT;
            end else if (int'(ord_ff) == MAX_ORDER - 1) begin
               st_in = B_ORD_RD;
            end else begin
               ord_in = ord_ff + 1'b1;
               st_in  = B_COV_RD;
            end
         end
         B_ORD_RD: begin
            mem_re = 1'b1;
            mem_ra = idx_ff;
            st_in  = B_ORD_CHK;
         end
         B_ORD_CHK: begin
            if (int'(rd_ff.order) >= MAX_ORDER ||
                (SPAN_W'(idx_ff) & (pow2(rd_ff.order) - 1'b1)) != '0 ||
                SPAN_W'(idx_ff) + pow2(rd_ff.order) > SPAN_W'(NUM_PAGES)) begin
               res_in.status = ST_RANGE;
               st_in         = B_EMIT;
            end else begin
               ord_in = rd_ff.order;
               p_in   = SPAN_W'(idx_ff);
               st_in  = B_MRG_RD;
            end
         end
         B_MRG_RD: begin
            if (int'(ord_ff) + 1 >= MAX_ORDER ||
                bud + pow2(ord_ff) > SPAN_W'(NUM_PAGES)) begin
               st_in = B_FREE_WR;
            end else begin
               mem_re = 1'b1;
               mem_ra = bud[PAGE_W-1:0];
               st_in  = B_MRG_CHK;
            end
         end
         B_MRG_CHK: begin
            if (rd_ff.free && rd_ff.order == ord_ff) begin
               mem_we = 1'b1;
               mem_wa = bud[PAGE_W-1:0];
               mem_wd = '{free: 1'b0, order: rd_ff.order};
               cnt_we = 1'b1;
               if (bud < p_ff) begin
                  p_in = bud;
               end
               ord_in = ord_ff + 1'b1;
               st_in  = B_MRG_RD;
            end else begin
               st_in = B_FREE_WR;
            end
         end
         B_FREE_WR: begin
            mem_we = 1'b1;
            mem_wa = p_ff[PAGE_W-1:0];
            mem_wd = '{free: 1'b1, order: ord_ff};
            cnt_we = 1'b1;
            cnt_up = 1'b1;
            res_in = '{page: p_ff[PAGE_W-1:0], order: ord_ff, status: ST_OK};
            st_in  = B_EMIT;
         end
         B_SCAN_RD: begin
            if (p_ff >= SPAN_W'(NUM_PAGES)) begin
               res_in.status = ST_OOM;
               st_in         = B_EMIT;
            end else begin
               mem_re = 1'b1;
               mem_ra = p_ff[PAGE_W-1:0];
               st_in  = B_SCAN_CHK;
            end
         end
         B_SCAN_CHK: begin
            if (rd_ff.free && rd_ff.order == ord_ff) begin
               cnt_we = 1'b1;
               st_in  = B_SPLIT;
            end else begin
               p_in  = p_ff + pow2(ord_ff);
               st_in = B_SCAN_RD;
            end
         end
         B_SPLIT: begin
            if (ord_ff > req_ord_ff) begin
               ord_in = ord_dn;
               if (half < SPAN_W'(NUM_PAGES)) begin
                  mem_we  = 1'b1;
                  mem_wa  = half[PAGE_W-1:0];
                  mem_wd  = '{free: 1'b1, order: ord_dn};
                  cnt_we  = 1'b1;
                  cnt_up  = 1'b1;
                  cnt_idx = ord_dn[CIDX_W-1:0];
               end
            end else begin
               st_in = B_ALLOC_WR;
            end
         end
         B_ALLOC_WR: begin
            mem_we = 1'b1;
            mem_wa = p_ff[PAGE_W-1:0];
            mem_wd = '{free: 1'b0, order: req_ord_ff};
            res_in = '{page: p_ff[PAGE_W-1:0], order: req_ord_ff, status: ST_OK};
            st_in  = B_EMIT;
         end
         B_EMIT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               st_in        = B_IDLE;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int o = 0; o < MAX_ORDER; o++) begin
            cnt_ff[o] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         for (int o = 0; o < MAX_ORDER; o++) begin
            cnt_ff[o] <= cnt_in[o];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      ord_ff     <= ord_in;
      req_ord_ff <= req_ord_in;
      p_ff       <= p_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   assign back_status.init_done = (st_ff != B_CLEAR);
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.block_page     = out_ff.page;
   assign rsp_ch.block_order    = out_ff.order;
   assign rsp_ch.status         = out_ff.status;
endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// Top level of the buddy page allocator: front end, command queue and back end.
//
// Binary buddy allocator over 4096 pages with orders 0 to 9; every request word
// gives exactly one response word, in order. After reset a clearing pass
// zeroes the page state memory, and no request is taken until it ends. For a
// free, the double-free check reads one page entry per order, and each merge
// step is one read and one write on the page memory. An allocate scans the page
// entries at the chosen order, one read per entry, and then splits the block
// down to the requested order. Errors found at the front end go straight to
// the response in the back end. Up to two requests queue ahead of the back
// end, and a finished response waits in its own register.
`timescale 1ns / 1ps
module buddy_page_allocator (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_ch,
   bpa_rsp_if.source  rsp_ch
);
   import bpa_pkg::*;

   fifo_status_type  fifo_status;
   back_status_type  back_status;
   logic             push;
   logic             pop;
   cmd_type          push_data;
   cmd_type          pop_data;

   bpa_front u_front (
      .req_ch      (req_ch),
      .fifo_status (fifo_status),
      .back_status (back_status),
      .push        (push),
      .entry       (push_data)
   );

   bpa_cmd_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .pop         (pop),
      .pop_data    (pop_data),
      .fifo_status (fifo_status)
   );

   bpa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .cmd         (pop_data),
      .pop         (pop),
      .back_status (back_status),
      .rsp_ch      (rsp_ch)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("Request word pushed into a full command queue.");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("Command popped from an empty queue.");

   a_ready_after_init: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> back_status.init_done)
      else $error("Request word taken during the clearing pass.");

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      !back_status.init_done |-> !rsp_ch.valid)
      else $error("Response word shown during the clearing pass.");
endmodule
